>>> rtl/rmvm_pkg.sv
`timescale 1ns / 1ps
package rmvm_pkg;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int SUM_BITS        = 64;
   localparam int ROOT_BITS       = 32;
   localparam int OUT_BITS        = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVM,
      ST_EVAL,
      ST_MULS,
      ST_VSTART,
      ST_VARD,
      ST_ROOT,
      ST_DONE
   } state_type;
endpackage

>>> rtl/rmvm_div.sv
`timescale 1ns / 1ps
module rmvm_div #(
   parameter int DIVISOR_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rmvm_pkg::SUM_BITS-1:0]     dividend,
   input  logic [DIVISOR_BITS-1:0]           divisor,
   output logic                              done,
   output logic [rmvm_pkg::SUM_BITS-1:0]     quotient
);
   import rmvm_pkg::*;

   localparam int CW = $clog2(SUM_BITS);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CW-1:0]           cnt_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] rem_in;
   logic [DIVISOR_BITS-1:0] div_ff;
   logic [SUM_BITS-1:0]     quo_ff;
   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   diff;
   logic                    ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_BITS-1]};
      ge     = trial >= {1'b0, div_ff};
      diff   = trial - {1'b0, div_ff};
      rem_in = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[SUM_BITS-2:0], ge};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(SUM_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/rmvm_mul.sv
`timescale 1ns / 1ps
module rmvm_mul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           done,
   output logic [2*W-1:0] product
);
   localparam int CW = $clog2(W + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [W-1:0]   a_ff;
   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] prod_in;
   logic [W:0]     sum;

   always_comb begin
      sum     = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      prod_in = {sum, prod_ff[W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= a;
            prod_ff <= {{W{1'b0}}, b};
         end else if (busy_ff) begin
            prod_ff <= prod_in;
            cnt_ff  <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;
endmodule

>>> rtl/rmvm_sqrt.sv
`timescale 1ns / 1ps
module rmvm_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rmvm_pkg::SUM_BITS-1:0]  value,
   output logic                           done,
   output logic [rmvm_pkg::ROOT_BITS-1:0] root
);
   import rmvm_pkg::*;

   localparam int RB  = ROOT_BITS;
   localparam int RW  = RB + 4;
   localparam int CW  = $clog2(RB + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [RW-1:0]       rem_ff;
   logic [RW-1:0]       rem_in;
   logic [RW-1:0]       shifted;
   logic [RW-1:0]       trial;
   logic [SUM_BITS-1:0] val_ff;
   logic [RB-1:0]       root_ff;
   logic                ge;

   always_comb begin
      shifted = {rem_ff[RW-3:0], val_ff[SUM_BITS-1:SUM_BITS-2]};
      trial   = {{(RW-RB-2){1'b0}}, root_ff, 2'b01};
      ge      = shifted >= trial;
      rem_in  = ge ? shifted - trial : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
            val_ff  <= value;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            root_ff <= {root_ff[RB-2:0], ge};
            val_ff  <= {val_ff[SUM_BITS-3:0], 2'b00};
            cnt_ff  <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(RB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

>>> rtl/running_mean_variance_minmax_top.sv
`timescale 1ns / 1ps
// Running statistics (Welford mean and variance with minimum and maximum) over signed Q15.16
// samples. One transaction is processed at a time. It uses the bit-serial divider, which is
// shared by the mean update and the variance, the bit-serial multiplier for the product of
// the deviations from the old and the new mean, and the two-bit-per-cycle square root. A
// refused, first or non-finite sample skips the mean divide and the multiply. A finished
// result waits in an output register while the next transaction is accepted.
module running_mean_variance_minmax_top #(
   parameter int SAMPLE_BITS = rmvm_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmvm_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rmvm_pkg::OUT_BITS-1:0] req_sample,
   input  logic                                req_not_finite,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rmvm_pkg::OUT_BITS-1:0]        rsp_sample_count,
   output logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_minimum,
   output logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_maximum,
   output logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_running_mean,
   output logic [rmvm_pkg::SUM_BITS-1:0]        rsp_sample_variance,
   output logic [rmvm_pkg::ROOT_BITS-1:0]       rsp_std_deviation,
   output logic                                rsp_refused
);
   import rmvm_pkg::*;

   localparam int S = SAMPLE_BITS;
   localparam int C = COUNT_BITS;

   state_type state_ff, state_in;

   logic [C-1:0]          count_ff;
   logic signed [S-1:0]   low_ff, high_ff, mean_ff, mean_in, x_ff, x;
   logic [SUM_BITS-1:0]   sum_ff, sum_in, var_ff;
   logic signed [S:0]     d_ff, d_now, e_now, q;
   logic [S:0]            dmag_now, dmag_held, emag, qm;
   logic [SUM_BITS:0]     sat_sum;
   logic                  refused_ff, refuse, upd, accept, load;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   out_count_ff;
   logic signed [OUT_BITS-1:0] out_min_ff, out_max_ff, out_mean_ff;
   logic [SUM_BITS-1:0]   out_var_ff;
   logic [ROOT_BITS-1:0]  out_std_ff;
   logic                  out_ref_ff;

   logic                  div_start, div_done, mul_start, mul_done, sqrt_start, sqrt_done;
   logic [SUM_BITS-1:0]   div_dividend, quotient;
   logic [C-1:0]          div_divisor;
   logic [2*S-1:0]        product;
   logic [ROOT_BITS-1:0]  root;

   always_comb begin
      x         = req_sample[S-1:0];
      accept    = req_valid && req_ready;
      refuse    = req_not_finite || (&count_ff);
      upd       = !refuse && (count_ff != '0);
      d_now     = {x[S-1], x} - {mean_ff[S-1], mean_ff};
      dmag_now  = d_now[S] ? -d_now : d_now;
      dmag_held = d_ff[S] ? -d_ff : d_ff;
      qm        = quotient[S:0];
      q         = d_ff[S] ? -qm : qm;
      mean_in   = mean_ff + q[S-1:0];
      e_now     = {x_ff[S-1], x_ff} - {mean_ff[S-1], mean_ff};
      emag      = e_now[S] ? -e_now : e_now;
      sat_sum   = {1'b0, sum_ff} + {1'b0, SUM_BITS'(product)};
      sum_in    = sat_sum[SUM_BITS] ? '1 : sat_sum[SUM_BITS-1:0];
      load      = !rsp_valid_ff || rsp_ready;
      if (state_ff == ST_IDLE) begin
         div_dividend = SUM_BITS'(dmag_now);
         div_divisor  = count_ff + C'(1);
      end else if (count_ff > C'(1)) begin
         div_dividend = sum_ff;
         div_divisor  = count_ff - C'(1);
      end else begin
         div_dividend = '0;
         div_divisor  = C'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = upd ? ST_DIVM : ST_VSTART;
         ST_DIVM:   if (div_done) state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_MULS;
         ST_MULS:   if (mul_done) state_in = ST_VSTART;
         ST_VSTART: state_in = ST_VARD;
         ST_VARD:   if (div_done) state_in = ST_ROOT;
         ST_ROOT:   if (sqrt_done) state_in = ST_DONE;
         ST_DONE:   if (load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      div_start  = ((state_ff == ST_IDLE) && accept && upd) || (state_ff == ST_VSTART);
      mul_start  = (state_ff == ST_EVAL);
      sqrt_start = (state_ff == ST_VARD) && div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x_ff       <= x;
                  refused_ff <= refuse;
                  d_ff       <= d_now;
                  if (!refuse) begin
                     if (count_ff == '0) begin
                        low_ff   <= x;
                        high_ff  <= x;
                        mean_ff  <= x;
                        sum_ff   <= '0;
                        count_ff <= C'(1);
                     end else begin
                        if (x < low_ff) low_ff <= x;
                        if (x > high_ff) high_ff <= x;
                        count_ff <= count_ff + C'(1);
                     end
                  end
               end
            end
            ST_DIVM: if (div_done) mean_ff <= mean_in;
            ST_MULS: if (mul_done) sum_ff <= sum_in;
            ST_VARD: if (div_done) var_ff <= quotient;
            ST_DONE: begin
               if (load) begin
                  rsp_valid_ff <= 1'b1;
                  out_count_ff <= OUT_BITS'(count_ff);
                  out_min_ff   <= OUT_BITS'(low_ff);
                  out_max_ff   <= OUT_BITS'(high_ff);
                  out_mean_ff  <= OUT_BITS'(mean_ff);
                  out_var_ff   <= var_ff;
                  out_std_ff   <= root;
                  out_ref_ff   <= refused_ff;
               end
            end
            default: ;
         endcase
      end
   end

   rmvm_div #(.DIVISOR_BITS(C)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(quotient)
   );

   rmvm_mul #(.W(S)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(dmag_held[S-1:0]),
      .b(emag[S-1:0]), .done(mul_done), .product(product)
   );

   rmvm_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(quotient),
      .done(sqrt_done), .root(root)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_count    = out_count_ff;
   assign rsp_minimum         = out_min_ff;
   assign rsp_maximum         = out_max_ff;
   assign rsp_running_mean    = out_mean_ff;
   assign rsp_sample_variance = out_var_ff;
   assign rsp_std_deviation   = out_std_ff;
   assign rsp_refused         = out_ref_ff;
endmodule

>>> rtl/rmvm_checker.sv
`timescale 1ns / 1ps
module rmvm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rmvm_pkg::OUT_BITS-1:0]        rsp_sample_count,
   input logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_minimum,
   input logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_maximum,
   input logic signed [rmvm_pkg::OUT_BITS-1:0] rsp_running_mean,
   input logic [rmvm_pkg::SUM_BITS-1:0]        rsp_sample_variance,
   input logic [rmvm_pkg::ROOT_BITS-1:0]       rsp_std_deviation
);
   import rmvm_pkg::*;

   logic [SUM_BITS-1:0] std_sq;
   assign std_sq = SUM_BITS'(rsp_std_deviation) * SUM_BITS'(rsp_std_deviation);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // Only one transaction is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   a_var_small_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_count < 2) |-> rsp_sample_variance == '0)
      else $error("variance reported below two samples");

   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_count != '0) |->
         (rsp_minimum <= rsp_running_mean) && (rsp_running_mean <= rsp_maximum))
      else $error("mean outside the minimum and maximum");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> std_sq <= rsp_sample_variance)
      else $error("standard deviation exceeds the root of the variance");
endmodule

bind running_mean_variance_minmax_top rmvm_checker u_rmvm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_count(rsp_sample_count),
   .rsp_minimum(rsp_minimum), .rsp_maximum(rsp_maximum),
   .rsp_running_mean(rsp_running_mean), .rsp_sample_variance(rsp_sample_variance),
   .rsp_std_deviation(rsp_std_deviation)
);
